// ===== design/stripe_sector_mapper_top_macros.svh =====
`ifndef STRIPE_SECTOR_MAPPER_TOP_MACROS_SVH
`define STRIPE_SECTOR_MAPPER_TOP_MACROS_SVH

// checks that are masked while reset is high
`define SSM_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("stripe mapper check failed");

// checks that also hold during reset
`define SSM_CHECK_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("stripe mapper check failed");

`endif

// ===== design/ssm_pkg.sv =====
package ssm_pkg;

   typedef enum logic [1:0] {
      MODE_MAP   = 2'd0,
      MODE_FLUSH = 2'd1,
      MODE_RANGE = 2'd2,
      MODE_LOAD  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_REMAPPED = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_BAD      = 2'd2,
      ST_LOADED   = 2'd3
   } status_type;

   localparam logic [1:0] CSR_STRIPE_COUNT  = 2'd0;
   localparam logic [1:0] CSR_CHUNK_SECTORS = 2'd1;
   localparam logic [1:0] CSR_VOLUME_BEGIN  = 2'd2;

   localparam logic [4:0]  STRIPE_COUNT_RESET = 5'd1;
   localparam logic [31:0] CHUNK_RESET        = 32'd8;
   localparam int          NS_W               = 5;

   typedef struct packed {
      logic en;
      logic valid;
   } pipe_ctl_type;

endpackage

// ===== design/ssm_div.sv =====
module ssm_div #(
   parameter int NW = 64,
   parameter int DW = 32,
   parameter int PW = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ssm_pkg::pipe_ctl_type ctl,
   input  logic [NW-1:0]         n_b,
   input  logic [NW-1:0]         n_e,
   input  logic [DW-1:0]         d,
   input  logic [PW-1:0]         pay_in,
   output logic                  out_valid,
   output logic [NW-1:0]         q_b,
   output logic [NW-1:0]         q_e,
   output logic [DW-1:0]         r_b,
   output logic [DW-1:0]         r_e,
   output logic [PW-1:0]         pay_out
);
   import ssm_pkg::*;

   logic          v_ff   [NW];
   logic [NW-1:0] nb_ff  [NW];
   logic [NW-1:0] ne_ff  [NW];
   logic [DW-1:0] rb_ff  [NW];
   logic [DW-1:0] re_ff  [NW];
   logic [PW-1:0] pay_ff [NW];

   // one quotient bit per stage, most significant first
   for (genvar i = 0; i < NW; i++) begin : g_stage
      logic          v_src;
      logic [NW-1:0] nb_src, ne_src;
      logic [DW-1:0] rb_src, re_src;
      logic [PW-1:0] pay_src;
      logic [DW:0]   tb, te;
      logic          geb, gee;
      logic [NW-1:0] nb_in, ne_in;
      logic [DW-1:0] rb_in, re_in;

      if (i == 0) begin : g_first
         assign v_src   = ctl.valid;
         assign nb_src  = n_b;
         assign ne_src  = n_e;
         assign rb_src  = '0;
         assign re_src  = '0;
         assign pay_src = pay_in;
      end else begin : g_next
         assign v_src   = v_ff[i-1];
         assign nb_src  = nb_ff[i-1];
         assign ne_src  = ne_ff[i-1];
         assign rb_src  = rb_ff[i-1];
         assign re_src  = re_ff[i-1];
         assign pay_src = pay_ff[i-1];
      end

      always_comb begin
         tb    = {rb_src, nb_src[NW-1]};
         te    = {re_src, ne_src[NW-1]};
         geb   = tb >= {1'b0, d};
         gee   = te >= {1'b0, d};
         rb_in = geb ? DW'(tb - {1'b0, d}) : tb[DW-1:0];
         re_in = gee ? DW'(te - {1'b0, d}) : te[DW-1:0];
         nb_in = {nb_src[NW-2:0], geb};
         ne_in = {ne_src[NW-2:0], gee};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (ctl.en) begin
            v_ff[i] <= v_src;
         end
         if (ctl.en) begin
            nb_ff[i]  <= nb_in;
            ne_ff[i]  <= ne_in;
            rb_ff[i]  <= rb_in;
            re_ff[i]  <= re_in;
            pay_ff[i] <= pay_src;
         end
      end
   end

   assign out_valid = v_ff[NW-1];
   assign q_b       = nb_ff[NW-1];
   assign q_e       = ne_ff[NW-1];
   assign r_b       = rb_ff[NW-1];
   assign r_e       = re_ff[NW-1];
   assign pay_out   = pay_ff[NW-1];

endmodule

// ===== design/stripe_sector_mapper_top.sv =====
// Striped volume address mapper. One request transfer can be taken every clock while no result
// waits on rsp_tready; its result is presented by a pipeline of 2*SECTOR_BITS+3 register
// stages (SECTOR_BITS for the chunk divider, SECTOR_BITS for the stripe divider, one for the
// partial products, one for the sum and the device start table read and one output register),
// the first of which loads at the request transfer. The whole pipeline holds while a result
// waits on rsp_tready. Configuration may only change while no request is in flight. Table
// entries read before their first load return undefined data.
`include "stripe_sector_mapper_top_macros.svh"

module stripe_sector_mapper_top #(
   parameter int MAX_STRIPES = 16,
   parameter int SECTOR_BITS = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sector, length, stripe_index, device_start
   input  logic [((SECTOR_BITS+100+7)/8)*8-1:0]     req_tdata,
   // mode
   input  logic [1:0]                               req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // device, mapped_sector, mapped_length
   output logic [103:0]                             rsp_tdata,
   // status
   output logic [1:0]                               rsp_tuser,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [1:0]                               csr_index,
   input  logic [63:0]                              csr_data
);
   import ssm_pkg::*;

   localparam int SB  = SECTOR_BITS;
   localparam int TW  = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
   localparam int PW1 = SB + 102;
   localparam int PW2 = PW1 + 64;

   logic [4:0]  stripe_count_ff;
   logic [31:0] chunk_ff;
   logic [63:0] vbeg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stripe_count_ff <= STRIPE_COUNT_RESET;
         chunk_ff        <= CHUNK_RESET;
         vbeg_ff         <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_STRIPE_COUNT:  stripe_count_ff <= csr_data[4:0];
            CSR_CHUNK_SECTORS: chunk_ff        <= csr_data[31:0];
            CSR_VOLUME_BEGIN:  vbeg_ff         <= csr_data;
            default: ;
         endcase
      end
   end

   logic [NS_W-1:0] ns;
   logic [31:0]     chunk;

   always_comb begin
      if (stripe_count_ff == '0) begin
         ns = NS_W'(1);
      end else if (32'(stripe_count_ff) > MAX_STRIPES) begin
         ns = NS_W'(MAX_STRIPES);
      end else begin
         ns = stripe_count_ff;
      end
      chunk = (chunk_ff == '0) ? 32'd1 : chunk_ff;
   end

   logic          rsp_valid_ff;
   pipe_ctl_type  ctl1, ctl2;
   logic          en;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   logic [SB-1:0] in_sec;
   logic [31:0]   in_len;
   logic [3:0]    in_tgt;
   logic [63:0]   in_dst;
   logic [SB-1:0] off_b, off_e;

   always_comb begin
      in_sec = req_tdata[SB-1:0];
      in_len = req_tdata[SB+31:SB];
      in_tgt = req_tdata[SB+35:SB+32];
      in_dst = req_tdata[SB+99:SB+36];
      off_b  = SB'(in_sec - vbeg_ff[SB-1:0]);
      off_e  = SB'(in_sec + SB'(in_len) - vbeg_ff[SB-1:0]);
      ctl1   = '{en: en, valid: req_tvalid};
   end

   logic          d1_valid;
   logic [SB-1:0] idx_b, idx_e;
   logic [31:0]   wb1, we1;
   logic [PW1-1:0] pay1;

   ssm_div #(.NW(SB), .DW(32), .PW(PW1)) u_chunk_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl1),
      .n_b       (off_b),
      .n_e       (off_e),
      .d         (chunk),
      .pay_in    ({req_tuser, in_sec, in_len, in_tgt, in_dst}),
      .out_valid (d1_valid),
      .q_b       (idx_b),
      .q_e       (idx_e),
      .r_b       (wb1),
      .r_e       (we1),
      .pay_out   (pay1)
   );

   assign ctl2 = '{en: en, valid: d1_valid};

   logic            d2_valid;
   logic [SB-1:0]   row_b, row_e;
   logic [NS_W-1:0] dev_b, dev_e;
   logic [PW2-1:0]  pay2;

   ssm_div #(.NW(SB), .DW(NS_W), .PW(PW2)) u_stripe_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl2),
      .n_b       (idx_b),
      .n_e       (idx_e),
      .d         (ns),
      .pay_in    ({pay1, wb1, we1}),
      .out_valid (d2_valid),
      .q_b       (row_b),
      .q_e       (row_e),
      .r_b       (dev_b),
      .r_e       (dev_e),
      .pay_out   (pay2)
   );

   // partial products stage
   logic            m_valid_ff;
   logic [63:0]     lob_ff, loe_ff;
   logic [31:0]     hib_ff, hie_ff;
   logic [NS_W-1:0] devb_ff, deve_ff;
   logic [PW2-1:0]  pm_ff;
   logic [63:0]     rowxb, rowxe;

   assign rowxb = 64'(row_b);
   assign rowxe = 64'(row_e);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= d2_valid;
      end
      if (en) begin
         lob_ff  <= rowxb[31:0] * chunk;
         loe_ff  <= rowxe[31:0] * chunk;
         hib_ff  <= 32'(rowxb[63:32] * chunk);
         hie_ff  <= 32'(rowxe[63:32] * chunk);
         devb_ff <= dev_b;
         deve_ff <= dev_e;
         pm_ff   <= pay2;
      end
   end

   logic [1:0]    m_mode;
   logic [3:0]    m_tgt;
   logic [63:0]   m_dst;
   logic          m_wr;
   logic [TW-1:0] m_raddr;

   always_comb begin
      m_mode  = pm_ff[PW2-1:PW2-2];
      m_tgt   = pm_ff[64+67:64+64];
      m_dst   = pm_ff[64+63:64];
      m_wr    = m_valid_ff && (m_mode == MODE_LOAD) && (32'(m_tgt) < MAX_STRIPES);
      m_raddr = (m_mode == MODE_MAP) ? TW'(devb_ff) : TW'(m_tgt);
   end

   // device start table, read and written in the same stage
   logic [63:0] tbl_mem [MAX_STRIPES];
   logic [63:0] rd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (m_wr) begin
            tbl_mem[TW'(m_tgt)] <= m_dst;
         end
         rd_ff <= tbl_mem[m_raddr];
      end
   end

   logic            a_valid_ff;
   logic [SB-1:0]   rcb_ff, rce_ff;
   logic [NS_W-1:0] adevb_ff, adeve_ff;
   logic [PW2-1:0]  pa_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= m_valid_ff;
      end
      if (en) begin
         rcb_ff   <= SB'(lob_ff + {hib_ff, 32'd0});
         rce_ff   <= SB'(loe_ff + {hie_ff, 32'd0});
         adevb_ff <= devb_ff;
         adeve_ff <= deve_ff;
         pa_ff    <= pm_ff;
      end
   end

   logic [1:0]    a_mode;
   logic [SB-1:0] a_sec;
   logic [31:0]   a_len, a_wb, a_we;
   logic [3:0]    a_tgt;
   logic [63:0]   a_dst;
   logic [SB-1:0] pos_b, rng_b, rng_e;
   logic [3:0]    dev_in;
   logic [63:0]   msec_in;
   logic [31:0]   mlen_in;
   status_type    st_in;
   logic          tgt_ok;

   always_comb begin
      a_mode = pa_ff[PW2-1:PW2-2];
      a_sec  = pa_ff[PW2-3:PW2-2-SB];
      a_len  = pa_ff[64+99:64+68];
      a_tgt  = pa_ff[64+67:64+64];
      a_dst  = pa_ff[64+63:64];
      a_wb   = pa_ff[63:32];
      a_we   = pa_ff[31:0];
      tgt_ok = {1'b0, a_tgt} < ns;
      pos_b  = SB'(rcb_ff + SB'(a_wb));
      if (4'(adevb_ff) == a_tgt) begin
         rng_b = pos_b;
      end else if (a_tgt < 4'(adevb_ff)) begin
         rng_b = SB'(rcb_ff + SB'(chunk));
      end else begin
         rng_b = rcb_ff;
      end
      if (4'(adeve_ff) == a_tgt) begin
         rng_e = SB'(rce_ff + SB'(a_we));
      end else if (a_tgt < 4'(adeve_ff)) begin
         rng_e = SB'(rce_ff + SB'(chunk));
      end else begin
         rng_e = rce_ff;
      end
      dev_in  = a_tgt;
      msec_in = '0;
      mlen_in = '0;
      st_in   = ST_BAD;
      case (a_mode)
         MODE_MAP: begin
            dev_in  = 4'(adevb_ff);
            msec_in = 64'(SB'(pos_b + rd_ff[SB-1:0]));
            mlen_in = a_len;
            st_in   = ST_REMAPPED;
         end
         MODE_FLUSH: begin
            if (tgt_ok) begin
               msec_in = 64'(a_sec);
               mlen_in = a_len;
               st_in   = ST_REMAPPED;
            end
         end
         MODE_RANGE: begin
            if (tgt_ok) begin
               if (rng_b < rng_e) begin
                  msec_in = 64'(SB'(rng_b + rd_ff[SB-1:0]));
                  mlen_in = 32'(rng_e - rng_b);
                  st_in   = ST_REMAPPED;
               end else begin
                  st_in = ST_EMPTY;
               end
            end
         end
         default: begin
            if (32'(a_tgt) < MAX_STRIPES) begin
               msec_in = a_dst;
               st_in   = ST_LOADED;
            end
         end
      endcase
   end

   logic [3:0]  dev_ff;
   logic [63:0] msec_ff;
   logic [31:0] mlen_ff;
   status_type  st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= a_valid_ff;
      end
      if (en) begin
         dev_ff  <= dev_in;
         msec_ff <= msec_in;
         mlen_ff <= mlen_in;
         st_ff   <= st_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, mlen_ff, msec_ff, dev_ff};
   assign rsp_tuser  = st_ff;

   `SSM_CHECK(a_empty_zero, rsp_tvalid && (rsp_tuser == ST_EMPTY) |-> (rsp_tdata[99:4] == '0))
   `SSM_CHECK(a_bad_zero, rsp_tvalid && (rsp_tuser == ST_BAD) |-> (rsp_tdata[99:4] == '0))
   `SSM_CHECK(a_stall_ready, rsp_tvalid && !rsp_tready |-> !req_tready)
   `SSM_CHECK_ALWAYS(a_reset_idle, $past(reset) && !reset |-> !rsp_tvalid)

endmodule
